// ===== hw/rtl/tstm_pkg.sv =====
package tstm_pkg;

  localparam int NUM_BREAKPOINTS = 8;
  localparam int BP_SPACING      = 1000;
  localparam int SPEED_TOP       = (NUM_BREAKPOINTS - 1) * BP_SPACING;

  localparam int SPD_W    = 15;
  localparam int THR_W    = 15;
  localparam int THR_FULL = 16384;
  localparam int SEG_W    = 5;
  localparam int REM_W    = 11;
  localparam int FRAC_W   = 10;
  localparam int NM_W     = 11;
  localparam int DIFF_W   = NM_W + 1;
  localparam int FD_W     = FRAC_W + 1 + DIFF_W;
  localparam int TQ_W     = 21;
  localparam int PROD_W   = 35;
  localparam int TOTAL_W  = 19;
  localparam int CORNER_W = 17;

  // Speed segment by reciprocal multiply; the estimate is exact or one low.
  localparam int RECIP_SEG    = 1048;
  localparam int RECIP_SEG_SH = 20;
  localparam int SEGM_W       = SPD_W + 11;

  // Divide by 64000 as a shift by 9 and a divide by 125.
  localparam int DIV_PRE_SH   = 9;
  localparam int X_W          = PROD_W - DIV_PRE_SH;
  localparam int DIV_POST     = 125;
  localparam int RECIP_DIV    = 68719476;
  localparam int RECIP_DIV_SH = 33;
  localparam int RECIP_DIV_W  = 27;
  localparam int QM_W         = X_W + RECIP_DIV_W;

  localparam int NUM_STAGES = 8;

  function automatic logic [NM_W-1:0] wot_nm(input logic [SEG_W-1:0] idx);
    logic [NM_W-1:0] v;
    unique case (idx)
      5'd0:    v = NM_W'(200);
      5'd1:    v = NM_W'(600);
      5'd2:    v = NM_W'(900);
      5'd3:    v = NM_W'(1050);
      5'd4:    v = NM_W'(1100);
      5'd5:    v = NM_W'(1050);
      5'd6:    v = NM_W'(900);
      default: v = NM_W'(600);
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/throttle_scaled_torque_map_top.sv =====
// Valid: start shifts through the stage valid bits alongside the data; out_valid is the last bit.
// Throughput: one item per cycle; busy is always low, as the eight-stage
// pipeline has no feedback and the receiver cannot stall.
// Reset: synchronous active-low rst_n clears the stage valid bits only.
module throttle_scaled_torque_map_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [15:0]            in_engine_speed,
  input  logic signed [15:0]            in_throttle_demand,
  output logic                          out_valid,
  output logic [tstm_pkg::TOTAL_W-1:0]  out_total_torque,
  output logic [tstm_pkg::CORNER_W-1:0] out_corner_torque
);

  logic [tstm_pkg::NUM_STAGES-1:0] vld_r;

  logic [tstm_pkg::SPD_W-1:0]   s1_spd_r, s2_spd_r;
  logic [tstm_pkg::THR_W-1:0]   s1_thr_r, s2_thr_r, s3_thr_r, s4_thr_r, s5_thr_r;
  logic [tstm_pkg::SEG_W-1:0]   s2_qe_r, s3_seg_r;
  logic [tstm_pkg::FRAC_W-1:0]  s3_frac_r;
  logic [tstm_pkg::TQ_W-1:0]    s4_lom_r, s5_tq_r;
  logic signed [tstm_pkg::FD_W-1:0] s4_fd_r;
  logic [tstm_pkg::PROD_W-1:0]  s6_prod_r;
  logic [tstm_pkg::X_W-1:0]     s7_x_r;
  logic [tstm_pkg::TOTAL_W-1:0] s7_qe_r, total_r;

  logic [tstm_pkg::SPD_W-1:0]   spd_nxt;
  logic [tstm_pkg::THR_W-1:0]   thr_nxt;
  logic [tstm_pkg::SEGM_W-1:0]  segm;
  logic [tstm_pkg::SPD_W-1:0]   segk;
  logic [tstm_pkg::REM_W-1:0]   rem;
  logic [tstm_pkg::SEG_W-1:0]   seg_nxt;
  logic [tstm_pkg::FRAC_W-1:0]  frac_nxt;
  logic [tstm_pkg::NM_W-1:0]    lo, hi;
  logic signed [tstm_pkg::DIFF_W-1:0] diff;
  logic signed [tstm_pkg::FD_W-1:0]   fd_nxt;
  logic signed [tstm_pkg::FD_W-1:0]   tq_sum;
  logic [tstm_pkg::X_W-1:0]     qk, xrem;
  logic [tstm_pkg::TOTAL_W-1:0] total_nxt;

  assign busy = 1'b0;

  always_comb begin
    if (in_engine_speed[15]) begin
      spd_nxt = '0;
    end else if (in_engine_speed[14:0] >= tstm_pkg::SPD_W'(tstm_pkg::SPEED_TOP)) begin
      spd_nxt = tstm_pkg::SPD_W'(tstm_pkg::SPEED_TOP);
    end else begin
      spd_nxt = in_engine_speed[14:0];
    end
    if (in_throttle_demand[15]) begin
      thr_nxt = '0;
    end else if (in_throttle_demand[14:0] > tstm_pkg::THR_W'(tstm_pkg::THR_FULL)) begin
      thr_nxt = tstm_pkg::THR_W'(tstm_pkg::THR_FULL);
    end else begin
      thr_nxt = in_throttle_demand[14:0];
    end
  end

  assign segm = tstm_pkg::SEGM_W'(s1_spd_r) * tstm_pkg::SEGM_W'(tstm_pkg::RECIP_SEG);

  always_comb begin
    segk = tstm_pkg::SPD_W'(s2_qe_r) * tstm_pkg::SPD_W'(tstm_pkg::BP_SPACING);
    rem  = tstm_pkg::REM_W'(s2_spd_r - segk);
    if (rem >= tstm_pkg::REM_W'(tstm_pkg::BP_SPACING)) begin
      seg_nxt  = s2_qe_r + 1'b1;
      frac_nxt = tstm_pkg::FRAC_W'(rem - tstm_pkg::REM_W'(tstm_pkg::BP_SPACING));
    end else begin
      seg_nxt  = s2_qe_r;
      frac_nxt = rem[tstm_pkg::FRAC_W-1:0];
    end
  end

  always_comb begin
    lo     = tstm_pkg::wot_nm(s3_seg_r);
    hi     = tstm_pkg::wot_nm(s3_seg_r + 1'b1);
    diff   = $signed({1'b0, hi}) - $signed({1'b0, lo});
    fd_nxt = $signed({1'b0, s3_frac_r}) * diff;
  end

  assign tq_sum = $signed({2'b00, s4_lom_r}) + s4_fd_r;

  always_comb begin
    qk   = tstm_pkg::X_W'(s7_qe_r) * tstm_pkg::X_W'(tstm_pkg::DIV_POST);
    xrem = s7_x_r - qk;
    if (xrem >= tstm_pkg::X_W'(tstm_pkg::DIV_POST)) begin
      total_nxt = s7_qe_r + 1'b1;
    end else begin
      total_nxt = s7_qe_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[tstm_pkg::NUM_STAGES-2:0], start};
    end
  end

  always_ff @(posedge clk) begin
    s1_spd_r  <= spd_nxt;
    s1_thr_r  <= thr_nxt;
    s2_spd_r  <= s1_spd_r;
    s2_thr_r  <= s1_thr_r;
    s2_qe_r   <= segm[tstm_pkg::RECIP_SEG_SH +: tstm_pkg::SEG_W];
    s3_seg_r  <= seg_nxt;
    s3_frac_r <= frac_nxt;
    s3_thr_r  <= s2_thr_r;
    s4_lom_r  <= tstm_pkg::TQ_W'(lo) * tstm_pkg::TQ_W'(tstm_pkg::BP_SPACING);
    s4_fd_r   <= fd_nxt;
    s4_thr_r  <= s3_thr_r;
    s5_tq_r   <= tq_sum[tstm_pkg::TQ_W-1:0];
    s5_thr_r  <= s4_thr_r;
    s6_prod_r <= tstm_pkg::PROD_W'(s5_thr_r) * tstm_pkg::PROD_W'(s5_tq_r);
    s7_x_r    <= s6_prod_r[tstm_pkg::PROD_W-1:tstm_pkg::DIV_PRE_SH];
    s7_qe_r   <= tstm_pkg::TOTAL_W'(s6_prod_r[tstm_pkg::PROD_W-1:tstm_pkg::DIV_PRE_SH]
                   * tstm_pkg::QM_W'(tstm_pkg::RECIP_DIV) >> tstm_pkg::RECIP_DIV_SH);
    total_r   <= total_nxt;
  end

  assign out_valid         = vld_r[tstm_pkg::NUM_STAGES-1];
  assign out_total_torque  = total_r;
  assign out_corner_torque = total_r[tstm_pkg::TOTAL_W-1:2];

endmodule
